@@ rtl/apm_pkg.sv @@
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types, constants and fixed-point helpers for the membrane rates unit.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int FRAC_DEF = 24;   // default fractional bits
  localparam int DATA_W   = 32;   // input and result field width
  localparam int REG_W    = 31;   // configuration register width
  localparam int CFG_IDX_W = 3;   // configuration index width
  localparam int DIV_W    = 33;   // divisor magnitude width (|u + mu2| < 2^32 + 1)
  localparam int DIV_STEP = 4;    // quotient bits per divider stage

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURRENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GATING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MU_ONE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MU_TWO       = 3'd5;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;
  localparam fx_t S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam fx_t S32_MIN = 64'shFFFF_FFFF_8000_0000;

  // partial products of a 64 x 64 magnitude multiply
  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } mpart_t;

  function automatic logic [63:0] mag64(fx_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic fx_t sadd(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return fx_t'(s[63:0]);
  endfunction

  function automatic fx_t ssub(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return fx_t'(s[63:0]);
  endfunction

  function automatic fx_t sneg(fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

  // first half of a product: four 32 x 32 partials of the magnitudes
  function automatic mpart_t mpart(fx_t x, fx_t y);
    logic [63:0] a;
    logic [63:0] b;
    mpart_t      p;
    a     = mag64(x);
    b     = mag64(y);
    p.neg = x[63] ^ y[63];
    p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
    p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
    p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  // second half: sum, round half away from zero, rescale and saturate
  function automatic fx_t mfin(mpart_t p, int frac);
    logic [127:0] full;
    logic [127:0] sh;
    full = {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
         + {p.p11, 64'd0};
    sh = (full + (128'd1 << (frac - 1))) >> frac;
    if (!p.neg) begin
      return (sh > 128'h7FFF_FFFF_FFFF_FFFF) ? FX_MAX : fx_t'(sh[63:0]);
    end
    return (sh >= 128'h8000_0000_0000_0000) ? FX_MIN : fx_t'(64'd0 - sh[63:0]);
  endfunction

  // scale by one quarter, rounded half away from zero
  function automatic fx_t qrt(fx_t x);
    logic [64:0] m;
    m = ({1'b0, mag64(x)} + 65'd2) >> 2;
    return x[63] ? fx_t'(64'd0 - m[63:0]) : fx_t'(m[63:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(fx_t x);
    if (x > S32_MAX) return S32_MAX[DATA_W-1:0];
    if (x < S32_MIN) return S32_MIN[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/apm_in_if.sv @@
// ----------------------------------------------------------------------------
// apm_in_if
// Input channel: one mesh point (potential and gating value) per transaction.
// ----------------------------------------------------------------------------
interface apm_in_if
  import apm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] potential;
  logic signed [DATA_W-1:0] gating_value;

  modport source (output valid, potential, gating_value, input ready);
  modport sink   (input valid, potential, gating_value, output ready);
endinterface

@@ rtl/apm_out_if.sv @@
// ----------------------------------------------------------------------------
// apm_out_if
// Result channel: six rates and the divide fault flag per transaction.
// ----------------------------------------------------------------------------
interface apm_out_if
  import apm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] ion_current;
  logic signed [DATA_W-1:0] current_by_u;
  logic signed [DATA_W-1:0] current_by_v;
  logic signed [DATA_W-1:0] gating_rate;
  logic signed [DATA_W-1:0] gating_rate_by_u;
  logic signed [DATA_W-1:0] gating_rate_by_v;
  logic                     div_fault;

  modport source (output valid, ion_current, current_by_u, current_by_v, gating_rate,
                  gating_rate_by_u, gating_rate_by_v, div_fault, input ready);
  modport sink   (input valid, ion_current, current_by_u, current_by_v, gating_rate,
                  gating_rate_by_u, gating_rate_by_v, div_fault, output ready);
endinterface

@@ rtl/apm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// apm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface apm_cfg_if
  import apm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/apm_div.sv @@
// ----------------------------------------------------------------------------
// apm_div
// Pipelined restoring divider, DIV_STEP quotient bits per stage, one or more
// dividends over a shared divisor, with passenger data carried alongside.
// ----------------------------------------------------------------------------
module apm_div
  import apm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF,
  parameter int LANES     = 1,
  parameter int SIDE_W    = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  fx_t               dvd_i [LANES],
  input  fx_t               dsr_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid,
  output fx_t               quo_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  localparam int STG = (64 + FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int QW  = STG * DIV_STEP;
  localparam logic [QW-1:0] QPOS_MAX = QW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [QW-1:0] QNEG_MAX = QW'(64'h8000_0000_0000_0000);

  logic [STG-1:0]    vld_r;
  logic [DIV_W-1:0]  rem_r   [STG][LANES];
  logic [QW-1:0]     dvd_r   [STG][LANES];
  logic [QW-1:0]     quo_r   [STG][LANES];
  logic              neg_r   [STG][LANES];
  logic              npos_r  [STG][LANES];
  logic [DIV_W-1:0]  md_r    [STG];
  logic              dz_r    [STG];
  logic [SIDE_W-1:0] side_r  [STG];

  logic [DIV_W-1:0]  rem_src [STG][LANES];
  logic [QW-1:0]     dvd_src [STG][LANES];
  logic [QW-1:0]     quo_src [STG][LANES];
  logic [DIV_W-1:0]  md_src  [STG];
  logic [DIV_W-1:0]  rem_nxt [STG][LANES];
  logic [QW-1:0]     dvd_nxt [STG][LANES];
  logic [QW-1:0]     quo_nxt [STG][LANES];

  // stage inputs: conversion at entry, previous stage otherwise
  always_comb begin
    logic [63:0] mn;
    logic [63:0] md;
    md        = mag64(dsr_i);
    md_src[0] = md[DIV_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      mn            = mag64(dvd_i[l]);
      rem_src[0][l] = '0;
      dvd_src[0][l] = QW'({mn, {FRAC_BITS{1'b0}}});
      quo_src[0][l] = '0;
    end
    for (int s = 1; s < STG; s++) begin
      md_src[s] = md_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        rem_src[s][l] = rem_r[s-1][l];
        dvd_src[s][l] = dvd_r[s-1][l];
        quo_src[s][l] = quo_r[s-1][l];
      end
    end
  end

  // compare-subtract steps of each stage
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    logic [QW-1:0]    dv;
    logic [QW-1:0]    qv;
    logic             qb;
    for (int s = 0; s < STG; s++) begin
      for (int l = 0; l < LANES; l++) begin
        r  = rem_src[s][l];
        dv = dvd_src[s][l];
        qv = quo_src[s][l];
        for (int k = 0; k < DIV_STEP; k++) begin
          t  = {r, dv[QW-1]};
          dv = dv << 1;
          qb = (t >= {1'b0, md_src[s]});
          if (qb) t = t - {1'b0, md_src[s]};
          r  = t[DIV_W-1:0];
          qv = {qv[QW-2:0], qb};
        end
        rem_nxt[s][l] = r;
        dvd_nxt[s][l] = dv;
        quo_nxt[s][l] = qv;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STG-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      md_r[0]   <= md_src[0];
      dz_r[0]   <= (dsr_i == '0);
      side_r[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        neg_r[0][l]  <= dvd_i[l][63] ^ dsr_i[63];
        npos_r[0][l] <= !dvd_i[l][63];
      end
      for (int s = 1; s < STG; s++) begin
        md_r[s]   <= md_r[s-1];
        dz_r[s]   <= dz_r[s-1];
        side_r[s] <= side_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          neg_r[s][l]  <= neg_r[s-1][l];
          npos_r[s][l] <= npos_r[s-1][l];
        end
      end
      for (int s = 0; s < STG; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          dvd_r[s][l] <= dvd_nxt[s][l];
          quo_r[s][l] <= quo_nxt[s][l];
        end
      end
    end
  end

  // sign, saturation and zero divisor
  always_comb begin
    logic [QW-1:0] qv;
    for (int l = 0; l < LANES; l++) begin
      qv = quo_r[STG-1][l];
      if (dz_r[STG-1]) begin
        quo_o[l] = npos_r[STG-1][l] ? FX_MAX : FX_MIN;
      end else if (!neg_r[STG-1][l]) begin
        quo_o[l] = (qv > QPOS_MAX) ? FX_MAX : fx_t'(qv[63:0]);
      end else begin
        quo_o[l] = (qv > QNEG_MAX) ? FX_MIN : fx_t'(64'd0 - qv[63:0]);
      end
    end
  end

  assign out_valid = vld_r[STG-1];
  assign side_o    = side_r[STG-1];

endmodule

@@ rtl/aliev_panfilov_membrane_rates_unit.sv @@
// ----------------------------------------------------------------------------
// aliev_panfilov_membrane_rates_unit
// Aliev-Panfilov membrane rates at one mesh point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one point (potential u, gating value v, signed fixed point
//           with FRAC_BITS fractional bits) per transaction.
//   out_ch  gives one result per point, in order: the ionic current, its u and
//           v derivatives, the gating rate, its u and v derivatives, and a flag
//           raised when u + mu2 is zero.
//   cfg_ch  writes the six model registers by index; always ready. The user
//           makes writes while no point is in flight; the block does not check.
// The pipeline has seven multiply/add stages, two pipelined dividers that
// resolve four quotient bits per stage, and four closing stages. One point is
// accepted every cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and in_ch.ready drops until it drains.
// Reset clears all valid bits and loads the default register values.
// ----------------------------------------------------------------------------
module aliev_panfilov_membrane_rates_unit
  import apm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input logic       clk,
  input logic       rst_n,
  apm_in_if.sink    in_ch,
  apm_out_if.source out_ch,
  apm_cfg_if.sink   cfg_ch
);

  localparam logic [63:0] ONE_U = 64'd1 << FRAC_BITS;
  localparam fx_t         ONE   = fx_t'(ONE_U);
  localparam logic [REG_W-1:0] RST_A   = REG_W'((ONE_U + 64'd5) / 64'd10);
  localparam logic [REG_W-1:0] RST_EPS = REG_W'((ONE_U + 64'd50) / 64'd100);
  localparam logic [REG_W-1:0] RST_G   = REG_W'(ONE_U * 64'd8);
  localparam logic [REG_W-1:0] RST_M1  = REG_W'((ONE_U * 64'd7 + 64'd50) / 64'd100);
  localparam logic [REG_W-1:0] RST_M2  = REG_W'((ONE_U * 64'd3 + 64'd5) / 64'd10);

  typedef struct packed {
    fx_t u; fx_t v; fx_t uma; fx_t um1; fx_t uma1; fx_t twoua; fx_t tum1; fx_t d;
  } s1_t;
  typedef struct packed {
    fx_t u; fx_t v; fx_t uma; fx_t um1; fx_t uma1; fx_t d;
    mpart_t gau; mpart_t uv; mpart_t pa; mpart_t pb; mpart_t gsu; mpart_t m1v;
    mpart_t gst;
  } s2_t;
  typedef struct packed {
    fx_t u; fx_t v; fx_t uma; fx_t um1; fx_t uma1; fx_t d;
    fx_t gau; fx_t uv; fx_t pa; fx_t pb; fx_t gsu; fx_t m1v; fx_t gst;
  } s3_t;
  typedef struct packed {
    fx_t u; fx_t v; fx_t um1; fx_t d; fx_t uv; fx_t m1v; fx_t gst;
    mpart_t gauma; mpart_t cdm; mpart_t gsuu;
  } s4_t;
  typedef struct packed {
    fx_t u; fx_t v; fx_t um1; fx_t d; fx_t uv; fx_t m1v; fx_t gst;
    fx_t gauma; fx_t cdm; fx_t gsuu;
  } s5_t;
  typedef struct packed {
    fx_t u; fx_t d; fx_t uv; fx_t m1v; fx_t gst; fx_t cdu; fx_t w;
    mpart_t ion;
  } s6_t;
  typedef struct packed {
    fx_t ion; fx_t cdu; fx_t u; fx_t w; fx_t gst; fx_t d;
  } d1_side_t;
  typedef struct packed {
    d1_side_t sd; fx_t m1v;
  } s7_t;
  typedef struct packed {
    fx_t ion; fx_t cdu; fx_t u; fx_t w; fx_t gst; fx_t base; logic fault;
  } d2_side_t;
  typedef struct packed {
    d2_side_t sd; fx_t q; fx_t d;
  } s8_t;
  typedef struct packed {
    fx_t ion; fx_t cdu; fx_t u; fx_t base; logic fault;
    mpart_t q2w; mpart_t bg; mpart_t rw; mpart_t qbw;
  } s9_t;
  typedef struct packed {
    fx_t ion; fx_t cdu; fx_t u; fx_t base; logic fault;
    fx_t t1; fx_t t2; fx_t t3; fx_t grate;
  } s10_t;
  typedef struct packed {
    logic signed [DATA_W-1:0] ion;
    logic signed [DATA_W-1:0] cdu;
    logic signed [DATA_W-1:0] cdv;
    logic signed [DATA_W-1:0] grate;
    logic signed [DATA_W-1:0] gdu;
    logic signed [DATA_W-1:0] gdv;
    logic                     fault;
  } res_t;

  // configuration registers
  logic [REG_W-1:0] thresh_a_r, eps_base_r, gain_current_r, gain_gating_r;
  logic [REG_W-1:0] mu_one_r, mu_two_r;

  fx_t a, eps, ga, gs, m1, m2;

  logic adv;
  logic [6:0] vld_r;
  logic v8_r, v9_r, v10_r, out_vld_r;

  s1_t  s1_r,  s1_nxt;
  s2_t  s2_r,  s2_nxt;
  s3_t  s3_r,  s3_nxt;
  s4_t  s4_r,  s4_nxt;
  s5_t  s5_r,  s5_nxt;
  s6_t  s6_r,  s6_nxt;
  s7_t  s7_r,  s7_nxt;
  s8_t  s8_r,  s8_nxt;
  s9_t  s9_r,  s9_nxt;
  s10_t s10_r, s10_nxt;
  res_t res_r, res_nxt;

  fx_t              d1_dvd [1];
  fx_t              d1_quo [1];
  logic             d1_vld;
  logic [$bits(d1_side_t)-1:0] d1_side_o;
  d1_side_t         d1_out;
  fx_t              d2_dvd [2];
  fx_t              d2_quo [2];
  logic             d2_vld;
  logic [$bits(d2_side_t)-1:0] d2_side_o;
  d2_side_t         d2_out;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_a_r     <= RST_A;
      eps_base_r     <= RST_EPS;
      gain_current_r <= RST_G;
      gain_gating_r  <= RST_G;
      mu_one_r       <= RST_M1;
      mu_two_r       <= RST_M2;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_THRESH_A:     thresh_a_r     <= cfg_ch.data[REG_W-1:0];
        REG_EPS_BASE:     eps_base_r     <= cfg_ch.data[REG_W-1:0];
        REG_GAIN_CURRENT: gain_current_r <= cfg_ch.data[REG_W-1:0];
        REG_GAIN_GATING:  gain_gating_r  <= cfg_ch.data[REG_W-1:0];
        REG_MU_ONE:       mu_one_r       <= cfg_ch.data[REG_W-1:0];
        REG_MU_TWO:       mu_two_r       <= cfg_ch.data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign a   = fx_t'({33'd0, thresh_a_r});
  assign eps = fx_t'({33'd0, eps_base_r});
  assign ga  = fx_t'({33'd0, gain_current_r});
  assign gs  = fx_t'({33'd0, gain_gating_r});
  assign m1  = fx_t'({33'd0, mu_one_r});
  assign m2  = fx_t'({33'd0, mu_two_r});

  // global advance: a free or draining output register lets every stage move
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: differences of u
  always_comb begin
    s1_nxt.u     = fx_t'(in_ch.potential);
    s1_nxt.v     = fx_t'(in_ch.gating_value);
    s1_nxt.uma   = ssub(s1_nxt.u, a);
    s1_nxt.um1   = ssub(s1_nxt.u, ONE);
    s1_nxt.uma1  = ssub(s1_nxt.uma, ONE);
    s1_nxt.twoua = ssub(sadd(s1_nxt.u, s1_nxt.u), a);
    s1_nxt.tum1  = ssub(s1_nxt.twoua, ONE);
    s1_nxt.d     = s1_nxt.u + m2;
  end

  // stage 2: first products, partials
  always_comb begin
    s2_nxt.u    = s1_r.u;
    s2_nxt.v    = s1_r.v;
    s2_nxt.uma  = s1_r.uma;
    s2_nxt.um1  = s1_r.um1;
    s2_nxt.uma1 = s1_r.uma1;
    s2_nxt.d    = s1_r.d;
    s2_nxt.gau  = mpart(ga, s1_r.u);
    s2_nxt.uv   = mpart(s1_r.u, s1_r.v);
    s2_nxt.pa   = mpart(s1_r.twoua, s1_r.um1);
    s2_nxt.pb   = mpart(s1_r.u, s1_r.uma);
    s2_nxt.gsu  = mpart(gs, s1_r.u);
    s2_nxt.m1v  = mpart(m1, s1_r.v);
    s2_nxt.gst  = mpart(gs, s1_r.tum1);
  end

  // stage 3: first products, finish
  always_comb begin
    s3_nxt.u    = s2_r.u;
    s3_nxt.v    = s2_r.v;
    s3_nxt.uma  = s2_r.uma;
    s3_nxt.um1  = s2_r.um1;
    s3_nxt.uma1 = s2_r.uma1;
    s3_nxt.d    = s2_r.d;
    s3_nxt.gau  = mfin(s2_r.gau, FRAC_BITS);
    s3_nxt.uv   = mfin(s2_r.uv, FRAC_BITS);
    s3_nxt.pa   = mfin(s2_r.pa, FRAC_BITS);
    s3_nxt.pb   = mfin(s2_r.pb, FRAC_BITS);
    s3_nxt.gsu  = mfin(s2_r.gsu, FRAC_BITS);
    s3_nxt.m1v  = mfin(s2_r.m1v, FRAC_BITS);
    s3_nxt.gst  = mfin(s2_r.gst, FRAC_BITS);
  end

  // stage 4: second products, partials
  always_comb begin
    s4_nxt.u     = s3_r.u;
    s4_nxt.v     = s3_r.v;
    s4_nxt.um1   = s3_r.um1;
    s4_nxt.d     = s3_r.d;
    s4_nxt.uv    = s3_r.uv;
    s4_nxt.m1v   = s3_r.m1v;
    s4_nxt.gst   = s3_r.gst;
    s4_nxt.gauma = mpart(s3_r.gau, s3_r.uma);
    s4_nxt.cdm   = mpart(ga, sadd(s3_r.pa, s3_r.pb));
    s4_nxt.gsuu  = mpart(s3_r.gsu, s3_r.uma1);
  end

  // stage 5: second products, finish
  always_comb begin
    s5_nxt.u     = s4_r.u;
    s5_nxt.v     = s4_r.v;
    s5_nxt.um1   = s4_r.um1;
    s5_nxt.d     = s4_r.d;
    s5_nxt.uv    = s4_r.uv;
    s5_nxt.m1v   = s4_r.m1v;
    s5_nxt.gst   = s4_r.gst;
    s5_nxt.gauma = mfin(s4_r.gauma, FRAC_BITS);
    s5_nxt.cdm   = mfin(s4_r.cdm, FRAC_BITS);
    s5_nxt.gsuu  = mfin(s4_r.gsuu, FRAC_BITS);
  end

  // stage 6: current slope with clamp, gating factor w, cubic term partials
  always_comb begin
    fx_t c;
    c            = ssub(sneg(s5_r.cdm), s5_r.v);
    s6_nxt.u     = s5_r.u;
    s6_nxt.d     = s5_r.d;
    s6_nxt.uv    = s5_r.uv;
    s6_nxt.m1v   = s5_r.m1v;
    s6_nxt.gst   = s5_r.gst;
    s6_nxt.cdu   = (c > 0) ? fx_t'(0) : c;
    s6_nxt.w     = ssub(sneg(s5_r.v), s5_r.gsuu);
    s6_nxt.ion   = mpart(s5_r.gauma, s5_r.um1);
  end

  // stage 7: ionic current
  always_comb begin
    s7_nxt.sd.ion = sneg(sadd(mfin(s6_r.ion, FRAC_BITS), s6_r.uv));
    s7_nxt.sd.cdu = s6_r.cdu;
    s7_nxt.sd.u   = s6_r.u;
    s7_nxt.sd.w   = s6_r.w;
    s7_nxt.sd.gst = s6_r.gst;
    s7_nxt.sd.d   = s6_r.d;
    s7_nxt.m1v    = s6_r.m1v;
  end

  // first divider: q = mu1 * v / (u + mu2)
  assign d1_dvd[0] = s7_r.m1v;

  apm_div #(
    .FRAC_BITS (FRAC_BITS),
    .LANES     (1),
    .SIDE_W    ($bits(d1_side_t))
  ) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vld_r[6]),
    .dvd_i     (d1_dvd),
    .dsr_i     (s7_r.sd.d),
    .side_i    (s7_r.sd),
    .out_valid (d1_vld),
    .quo_o     (d1_quo),
    .side_o    (d1_side_o)
  );

  assign d1_out = d1_side_o;

  // stage 8: recovery base rate
  always_comb begin
    s8_nxt.sd.ion   = d1_out.ion;
    s8_nxt.sd.cdu   = d1_out.cdu;
    s8_nxt.sd.u     = d1_out.u;
    s8_nxt.sd.w     = d1_out.w;
    s8_nxt.sd.gst   = d1_out.gst;
    s8_nxt.sd.base  = sadd(eps, d1_quo[0]);
    s8_nxt.sd.fault = (d1_out.d == '0);
    s8_nxt.q        = d1_quo[0];
    s8_nxt.d        = d1_out.d;
  end

  // second divider: q / (u + mu2) and mu1 / (u + mu2)
  assign d2_dvd[0] = s8_r.q;
  assign d2_dvd[1] = m1;

  apm_div #(
    .FRAC_BITS (FRAC_BITS),
    .LANES     (2),
    .SIDE_W    ($bits(d2_side_t))
  ) u_div_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v8_r),
    .dvd_i     (d2_dvd),
    .dsr_i     (s8_r.d),
    .side_i    (s8_r.sd),
    .out_valid (d2_vld),
    .quo_o     (d2_quo),
    .side_o    (d2_side_o)
  );

  assign d2_out = d2_side_o;

  // stage 9: gating products, partials
  always_comb begin
    s9_nxt.ion   = d2_out.ion;
    s9_nxt.cdu   = d2_out.cdu;
    s9_nxt.u     = d2_out.u;
    s9_nxt.base  = d2_out.base;
    s9_nxt.fault = d2_out.fault;
    s9_nxt.q2w   = mpart(d2_quo[0], d2_out.w);
    s9_nxt.bg    = mpart(d2_out.base, d2_out.gst);
    s9_nxt.rw    = mpart(d2_quo[1], d2_out.w);
    s9_nxt.qbw   = mpart(qrt(d2_out.base), d2_out.w);
  end

  // stage 10: gating products, finish
  always_comb begin
    s10_nxt.ion   = s9_r.ion;
    s10_nxt.cdu   = s9_r.cdu;
    s10_nxt.u     = s9_r.u;
    s10_nxt.base  = s9_r.base;
    s10_nxt.fault = s9_r.fault;
    s10_nxt.t1    = mfin(s9_r.q2w, FRAC_BITS);
    s10_nxt.t2    = mfin(s9_r.bg, FRAC_BITS);
    s10_nxt.t3    = mfin(s9_r.rw, FRAC_BITS);
    s10_nxt.grate = mfin(s9_r.qbw, FRAC_BITS);
  end

  // stage 11: gating slopes and 32-bit saturation into the output register
  always_comb begin
    fx_t gdv;
    gdv           = qrt(ssub(s10_r.t3, s10_r.base));
    res_nxt.ion   = sat32(s10_r.ion);
    res_nxt.cdu   = sat32(s10_r.cdu);
    res_nxt.cdv   = sat32(sneg(s10_r.u));
    res_nxt.grate = sat32(s10_r.grate);
    res_nxt.gdu   = sat32(qrt(ssub(sneg(s10_r.t1), s10_r.t2)));
    res_nxt.gdv   = sat32((gdv > 0) ? fx_t'(0) : gdv);
    res_nxt.fault = s10_r.fault;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      v8_r      <= 1'b0;
      v9_r      <= 1'b0;
      v10_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[5:0], in_ch.valid};
      v8_r      <= d1_vld;
      v9_r      <= d2_vld;
      v10_r     <= v9_r;
      out_vld_r <= v10_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s7_r  <= s7_nxt;
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      s10_r <= s10_nxt;
      res_r <= res_nxt;
    end
  end

  // result channel
  assign out_ch.valid            = out_vld_r;
  assign out_ch.ion_current      = res_r.ion;
  assign out_ch.current_by_u     = res_r.cdu;
  assign out_ch.current_by_v     = res_r.cdv;
  assign out_ch.gating_rate      = res_r.grate;
  assign out_ch.gating_rate_by_u = res_r.gdu;
  assign out_ch.gating_rate_by_v = res_r.gdv;
  assign out_ch.div_fault        = res_r.fault;

`ifndef SYNTHESIS
  // clamped slopes never come out positive
  a_cdu_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.current_by_u > 0))
    else $error("current_by_u above zero");

  a_gdv_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.gating_rate_by_v > 0))
    else $error("gating_rate_by_v above zero");

  // nothing is presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule
